### rtl/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg: shared types and constants for the RGB to HSV converter
// Channel widths, divider geometry, hue sector codes and stage records.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  localparam int ChanW     = 8;
  localparam int HueW      = 15;
  localparam int SatW      = 16;
  // quotient bits produced by the divider lanes (covers both hue and sat)
  localparam int QuotW     = 16;
  localparam int NumW      = ChanW + QuotW;
  localparam int DivSteps  = 4;
  localparam int DivStages = QuotW / DivSteps;
  // prep (two stages) + divider stages + output stage
  localparam int Latency   = DivStages + 3;

  localparam logic [HueW-1:0] HueFullTurn  = 15'd23040;
  localparam logic [HueW-1:0] HueBaseGreen = 15'd7680;
  localparam logic [HueW-1:0] HueBaseBlue  = 15'd15360;
  localparam logic [HueW-1:0] HueBaseZero  = 15'd0;

  // channel that holds the maximum (red wins ties, then green)
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } hue_sector_e;

  // one restoring-divider lane: partial remainder, pending dividend bits,
  // quotient built so far, divisor
  typedef struct packed {
    logic [ChanW-1:0] rem;
    logic [QuotW-1:0] num_lo;
    logic [QuotW-1:0] quot;
    logic [ChanW-1:0] dvs;
  } div_lane_t;

  // per-item data that rides alongside the divider lanes
  typedef struct packed {
    logic             neg;
    logic             gray;
    logic             black;
    logic [HueW-1:0]  base;
    logic [ChanW-1:0] value;
  } side_t;

  typedef struct packed {
    logic      valid;
    div_lane_t hue;
    div_lane_t sat;
    side_t     side;
  } div_item_t;

  // DivSteps restoring division steps, one quotient bit each
  function automatic div_lane_t div_steps(div_lane_t lane);
    div_lane_t        o;
    logic [ChanW:0]   r;
    o = lane;
    for (int i = 0; i < DivSteps; i++) begin
      r        = {o.rem, o.num_lo[QuotW-1]};
      o.num_lo = {o.num_lo[QuotW-2:0], 1'b0};
      if (r >= {1'b0, o.dvs}) begin
        o.rem  = ChanW'(r - {1'b0, o.dvs});
        o.quot = {o.quot[QuotW-2:0], 1'b1};
      end else begin
        o.rem  = r[ChanW-1:0];
        o.quot = {o.quot[QuotW-2:0], 1'b0};
      end
    end
    return o;
  endfunction

endpackage

### rtl/rgbhsv_prep.sv
// ----------------------------------------------------------------------------
// rgbhsv_prep: front end of the converter pipeline
// Stage 1 finds max, min, delta and the hue sector; stage 2 forms the two
// dividends and seeds the divider lanes.
// ----------------------------------------------------------------------------
module rgbhsv_prep import rgbhsv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  output div_item_t        item_o
);

  // stage 1 signals
  logic [ChanW-1:0] hi_c, lo_c, rg_max, rg_min;
  logic [ChanW-1:0] op_a, op_b;
  hue_sector_e      sector_c;

  logic             s1_valid_q;
  logic [ChanW-1:0] s1_hi_d, s1_hi_q;
  logic [ChanW-1:0] s1_delta_d, s1_delta_q;
  logic [ChanW-1:0] s1_absdiff_d, s1_absdiff_q;
  logic             s1_neg_d, s1_neg_q;
  hue_sector_e      s1_sector_q;

  // stage 2 signals
  logic [NumW-1:0]  num_hue, num_sat;
  logic [HueW-1:0]  base_c;
  div_item_t        item_d;
  logic             item_valid_q;
  div_lane_t        item_hue_q, item_sat_q;
  side_t            item_side_q;

  // max / min and sector pick
  always_comb begin
    rg_max = (red_i > green_i) ? red_i : green_i;
    rg_min = (red_i < green_i) ? red_i : green_i;
    hi_c   = (rg_max > blue_i) ? rg_max : blue_i;
    lo_c   = (rg_min < blue_i) ? rg_min : blue_i;
    if (hi_c == red_i) begin
      sector_c = SEC_RED;
      op_a     = green_i;
      op_b     = blue_i;
    end else if (hi_c == green_i) begin
      sector_c = SEC_GREEN;
      op_a     = blue_i;
      op_b     = red_i;
    end else begin
      sector_c = SEC_BLUE;
      op_a     = red_i;
      op_b     = green_i;
    end
    s1_hi_d      = hi_c;
    s1_delta_d   = hi_c - lo_c;
    s1_neg_d     = op_a < op_b;
    s1_absdiff_d = s1_neg_d ? (op_b - op_a) : (op_a - op_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_hi_q      <= s1_hi_d;
    s1_delta_q   <= s1_delta_d;
    s1_absdiff_q <= s1_absdiff_d;
    s1_neg_q     <= s1_neg_d;
    s1_sector_q  <= sector_c;
  end

  // dividends: 3840*|diff| for hue, 65535*delta for saturation
  always_comb begin
    num_hue = (NumW'(s1_absdiff_q) << 12) - (NumW'(s1_absdiff_q) << 8);
    num_sat = (NumW'(s1_delta_q) << QuotW) - NumW'(s1_delta_q);
    case (s1_sector_q)
      SEC_RED:   base_c = s1_neg_q ? HueFullTurn : HueBaseZero;
      SEC_GREEN: base_c = HueBaseGreen;
      SEC_BLUE:  base_c = HueBaseBlue;
      default:   base_c = HueBaseZero;
    endcase

    item_d.valid       = s1_valid_q;
    item_d.hue.rem     = num_hue[NumW-1:QuotW];
    item_d.hue.num_lo  = num_hue[QuotW-1:0];
    item_d.hue.quot    = '0;
    item_d.hue.dvs     = s1_delta_q;
    item_d.sat.rem     = num_sat[NumW-1:QuotW];
    item_d.sat.num_lo  = num_sat[QuotW-1:0];
    item_d.sat.quot    = '0;
    item_d.sat.dvs     = s1_hi_q;
    item_d.side.neg    = s1_neg_q;
    item_d.side.gray   = (s1_delta_q == '0);
    item_d.side.black  = (s1_hi_q == '0);
    item_d.side.base   = base_c;
    item_d.side.value  = s1_hi_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    item_hue_q  <= item_d.hue;
    item_sat_q  <= item_d.sat;
    item_side_q <= item_d.side;
  end

  assign item_o = {item_valid_q, item_hue_q, item_sat_q, item_side_q};

endmodule

### rtl/rgbhsv_div_stage.sv
// ----------------------------------------------------------------------------
// rgbhsv_div_stage: one slice of the pipelined divider
// Runs DivSteps restoring steps on both the hue and the saturation lane and
// registers the result together with the item's side data.
// ----------------------------------------------------------------------------
module rgbhsv_div_stage import rgbhsv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  div_item_t item_i,
  output div_item_t item_o
);

  div_lane_t hue_d, sat_d;
  logic      valid_q;
  div_lane_t hue_q, sat_q;
  side_t     side_q;

  // restoring steps for both lanes
  always_comb begin
    hue_d = div_steps(item_i.hue);
    sat_d = div_steps(item_i.sat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q  <= hue_d;
    sat_q  <= sat_d;
    side_q <= item_i.side;
  end

  assign item_o = {valid_q, hue_q, sat_q, side_q};

endmodule

### rtl/rgbhsv_post.sv
// ----------------------------------------------------------------------------
// rgbhsv_post: output stage of the converter
// Places the hue quotient around the sector base, applies the gray and black
// cases and registers the result item.
// ----------------------------------------------------------------------------
module rgbhsv_post import rgbhsv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_item_t        item_i,
  output logic             valid_o,
  output logic [HueW-1:0]  hue_o,
  output logic [SatW-1:0]  saturation_o,
  output logic [ChanW-1:0] brightness_o
);

  logic [HueW-1:0]  q_hue;
  logic [HueW-1:0]  hue_d, hue_q;
  logic [SatW-1:0]  sat_d, sat_q;
  logic             valid_q;
  logic [ChanW-1:0] value_q;

  // negative difference: floor(-x/d) = -(q + (rem != 0))
  always_comb begin
    q_hue = item_i.hue.quot[HueW-1:0];
    if (item_i.side.gray) begin
      hue_d = '0;
    end else if (item_i.side.neg) begin
      hue_d = item_i.side.base - q_hue - HueW'(item_i.hue.rem != '0);
    end else begin
      hue_d = item_i.side.base + q_hue;
    end
    sat_d = item_i.side.black ? '0 : item_i.sat.quot[SatW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q   <= hue_d;
    sat_q   <= sat_d;
    value_q <= item_i.side.value;
  end

  assign valid_o      = valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = value_q;

endmodule

### rtl/rgb_to_hsv.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv: pipelined RGB to HSV pixel converter
// Prep stages, a four-slice divider pipeline and an output stage.
// ----------------------------------------------------------------------------
// Usage: pulse start with a pixel on red_i/green_i/blue_i; busy is always
// low, so a pixel may be given in every clock cycle. Each pixel passes two
// prep stages, four divider slices of four quotient bits each and one output
// stage, and then comes out as a one-cycle valid_o strobe with hue_o in
// 1/64 degree, saturation_o with 65535 meaning 1.0, and brightness_o as the
// channel maximum. The receiver cannot stall the stream: results appear in
// input order and must be taken in the cycle they are shown.
// ----------------------------------------------------------------------------
module rgb_to_hsv import rgbhsv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  output logic             valid_o,
  output logic [HueW-1:0]  hue_o,
  output logic [SatW-1:0]  saturation_o,
  output logic [ChanW-1:0] brightness_o
);

  div_item_t pipe [DivStages+1];

  // no backpressure anywhere in the pipeline
  assign busy = 1'b0;

  rgbhsv_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .item_o  (pipe[0])
  );

  // divider slices
  for (genvar s = 0; s < DivStages; s++) begin : g_div
    rgbhsv_div_stage u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .item_i (pipe[s]),
      .item_o (pipe[s+1])
    );
  end

  rgbhsv_post u_post (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (pipe[DivStages]),
    .valid_o      (valid_o),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .brightness_o (brightness_o)
  );

`ifndef SYNTHESIS
  // every accepted item comes out after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##(Latency) valid_o)
    else $error("item lost in pipeline");

  // hue stays inside one full turn
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (hue_o < HueFullTurn))
    else $error("hue out of range");

  // a black pixel has no saturation and no hue
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && brightness_o == '0) |-> (saturation_o == '0 && hue_o == '0))
    else $error("black pixel with nonzero hue or saturation");
`endif

endmodule

### tb/sv/tb_rgb_to_hsv.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv: self-checking testbench for the RGB to HSV converter
// Drives directed corner pixels and then a long random stream with random
// gaps and gap-free bursts. A scoreboard predicts hue, saturation and value
// for every accepted item and checks each strobed result in order.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv;
  import rgbhsv_pkg::*;

  localparam int RandomPixels = 1200;
  localparam int CycleLimit   = 200000;
  localparam int DrainPoint   = 600;
  // fixed-point hue scaling: 1/64 degree units
  localparam int HueUnitsPer60  = 3840;
  localparam int HueUnitsPerDeg = 64;
  localparam int SatOne         = 65535;
  localparam int OffsetRed      = 360;
  localparam int OffsetGreen    = 120;
  localparam int OffsetBlue     = 240;

  // one predicted result, with the pixel that caused it for reporting
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [HueW-1:0]  hue;
    logic [SatW-1:0]  sat;
    logic [ChanW-1:0] value;
  } hsv_pixel_t;

  // in-order store of predicted HSV results
  class hsv_scoreboard;
    hsv_pixel_t pending_q[$];
    int         mismatches;

    function new();
      mismatches = 0;
    endfunction

    // fixed-point RGB to HSV conversion
    function hsv_pixel_t convert(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                                 logic [ChanW-1:0] b);
      hsv_pixel_t  px;
      hue_sector_e sector;
      int          rv, gv, bv, hi, lo, delta, diff, offset, quo;
      rv = r;
      gv = g;
      bv = b;
      hi = (rv > gv) ? rv : gv;
      hi = (hi > bv) ? hi : bv;
      lo = (rv < gv) ? rv : gv;
      lo = (lo < bv) ? lo : bv;
      delta = hi - lo;
      // first channel equal to the max picks the sector
      if (rv == hi) sector = SEC_RED;
      else if (gv == hi) sector = SEC_GREEN;
      else sector = SEC_BLUE;
      px.red   = r;
      px.green = g;
      px.blue  = b;
      px.hue   = '0;
      if (delta != 0) begin
        case (sector)
          SEC_RED: begin
            diff   = gv - bv;
            offset = OffsetRed;
          end
          SEC_GREEN: begin
            diff   = bv - rv;
            offset = OffsetGreen;
          end
          default: begin
            diff   = rv - gv;
            offset = OffsetBlue;
          end
        endcase
        quo = (HueUnitsPer60 * diff + HueUnitsPerDeg * offset * delta) / delta;
        if (quo >= int'(HueFullTurn)) quo = quo - int'(HueFullTurn);
        px.hue = HueW'(quo);
      end
      // black pixel gives zero saturation
      px.sat   = (hi == 0) ? '0 : SatW'((delta * SatOne) / hi);
      px.value = ChanW'(hi);
      return px;
    endfunction

    function void note_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                             logic [ChanW-1:0] b);
      pending_q.push_back(convert(r, g, b));
    endfunction

    function void check_result(logic [HueW-1:0] h, logic [SatW-1:0] s,
                               logic [ChanW-1:0] v);
      hsv_pixel_t exp_px;
      if (pending_q.size() == 0) begin
        $display("%0t: result with none pending: hue %0d sat %0d value %0d",
                 $time, h, s, v);
        mismatches++;
        return;
      end
      exp_px = pending_q.pop_front();
      if (h !== exp_px.hue) begin
        $display("%0t: rgb (%0d,%0d,%0d) hue expected %0d actual %0d", $time,
                 exp_px.red, exp_px.green, exp_px.blue, exp_px.hue, h);
        mismatches++;
      end
      if (s !== exp_px.sat) begin
        $display("%0t: rgb (%0d,%0d,%0d) sat expected %0d actual %0d", $time,
                 exp_px.red, exp_px.green, exp_px.blue, exp_px.sat, s);
        mismatches++;
      end
      if (v !== exp_px.value) begin
        $display("%0t: rgb (%0d,%0d,%0d) value expected %0d actual %0d", $time,
                 exp_px.red, exp_px.green, exp_px.blue, exp_px.value, v);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [ChanW-1:0] red_i;
  logic [ChanW-1:0] green_i;
  logic [ChanW-1:0] blue_i;
  logic             valid_o;
  logic [HueW-1:0]  hue_o;
  logic [SatW-1:0]  saturation_o;
  logic [ChanW-1:0] brightness_o;

  hsv_scoreboard sb;
  int            burst_left = 0;
  int            cycle_count = 0;

  rgb_to_hsv dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .valid_o     (valid_o),
    .hue_o       (hue_o),
    .saturation_o(saturation_o),
    .brightness_o(brightness_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // monitor: check strobed results, record accepted items
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) sb.check_result(hue_o, saturation_o, brightness_o);
      if (start && !busy) sb.note_pixel(red_i, green_i, blue_i);
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // sender gap: mostly drawn at random, with occasional gap-free bursts
  function automatic int pick_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  // present one item and hold it until accepted; start stays high into
  // the next item when no gap is drawn
  task automatic drive_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                             logic [ChanW-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    red_i   <= r;
    green_i <= g;
    blue_i  <= b;
    do @(posedge clk_i); while (busy);
  endtask

  // step the clock before checking so the monitor has noted the last accepted item
  task automatic wait_drained();
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin
    logic [ChanW-1:0] r, g, b;
    int               kind;
    sb = new();
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    red_i   <= '0;
    green_i <= '0;
    blue_i  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: black, gray, primaries, ties, hue wrap, small deltas
    drive_pixel(8'd0,   8'd0,   8'd0);
    drive_pixel(8'd255, 8'd255, 8'd255);
    drive_pixel(8'd128, 8'd128, 8'd128);
    drive_pixel(8'd255, 8'd0,   8'd0);
    drive_pixel(8'd0,   8'd255, 8'd0);
    drive_pixel(8'd0,   8'd0,   8'd255);
    drive_pixel(8'd255, 8'd255, 8'd0);
    drive_pixel(8'd0,   8'd255, 8'd255);
    drive_pixel(8'd255, 8'd0,   8'd255);
    drive_pixel(8'd255, 8'd0,   8'd1);
    drive_pixel(8'd255, 8'd1,   8'd0);
    drive_pixel(8'd1,   8'd0,   8'd0);
    drive_pixel(8'd0,   8'd0,   8'd1);
    drive_pixel(8'd1,   8'd1,   8'd0);
    drive_pixel(8'd255, 8'd254, 8'd254);
    drive_pixel(8'd254, 8'd255, 8'd255);
    drive_pixel(8'd10,  8'd20,  8'd30);
    drive_pixel(8'd30,  8'd20,  8'd10);
    drive_pixel(8'd200, 8'd100, 8'd150);
    drive_pixel(8'd85,  8'd170, 8'd255);
    drive_pixel(8'd170, 8'd255, 8'd85);

    // random stream with a bias toward ties, grays and tiny values
    for (int i = 0; i < RandomPixels; i++) begin
      if (i == DrainPoint) begin
        start <= 1'b0;
        wait_drained();
      end
      r    = ChanW'($urandom);
      g    = ChanW'($urandom);
      b    = ChanW'($urandom);
      kind = $urandom_range(0, 9);
      case (kind)
        0: g = r;
        1: b = g;
        2: b = r;
        3: begin
          g = r;
          b = r;
        end
        4: begin
          r = ChanW'($urandom_range(0, 3));
          g = ChanW'($urandom_range(0, 3));
          b = ChanW'($urandom_range(0, 3));
        end
        5: begin
          // near-gray around a random level
          g = r ^ ChanW'($urandom_range(0, 1));
          b = r ^ ChanW'($urandom_range(0, 1));
        end
        default: ;
      endcase
      drive_pixel(r, g, b);
    end
    start <= 1'b0;

    wait_drained();
    repeat (Latency + 4) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
rtl/rgbhsv_pkg.sv
rtl/rgbhsv_prep.sv
rtl/rgbhsv_div_stage.sv
rtl/rgbhsv_post.sv
rtl/rgb_to_hsv.sv
tb/sv/tb_rgb_to_hsv.sv
